### rtl/decq_pkg.sv
`timescale 1ns / 1ps
// package for the debounced event counter queue
// holds widths, command codes, register indexes and the item, slot and command types
package decq_pkg;

  localparam int QUEUE_DEPTH  = 64;
  localparam int NUM_CHANNELS = 3;

  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int CH_SEL_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  // channels that have a reset mask bit
  localparam int NUM_RST  = (NUM_CHANNELS < 3) ? NUM_CHANNELS : 3;

  localparam int CMD_W    = 2;
  localparam int CHAN_W   = 2;
  localparam int MASK_W   = 3;
  localparam int TIME_W   = 32;
  localparam int COUNT_W  = 31;
  localparam int SEQ_W    = 31;
  localparam int LEVEL_W  = 6;
  localparam int AFL_W    = 7;
  localparam int CMP_W    = (PTR_W > AFL_W) ? PTR_W + 1 : AFL_W + 1;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALMOST_FULL = 1'd1;

  localparam logic [TIME_W-1:0]  DEBOUNCE_RESET = 32'd500;
  localparam logic [AFL_W-1:0]   AFL_RESET      = 7'd58;
  localparam logic [COUNT_W-1:0] COUNT_MAX      = '1;

  localparam logic [CMD_W-1:0] CMD_EDGE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RESET = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POP   = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [CHAN_W-1:0] channel;
    logic [MASK_W-1:0] reset_low_mask;
    logic [TIME_W-1:0] now_ms;
    logic [TIME_W-1:0] wall_time;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  chan;
    logic [TIME_W-1:0]  wall;
    logic [TIME_W-1:0]  millis;
    logic [COUNT_W-1:0] count;
    logic [SEQ_W-1:0]   seq;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef struct packed {
    logic               edge_accepted;
    logic               event_queued;
    logic               event_dropped;
    logic               reset_done;
    logic               event_valid;
    logic [CHAN_W-1:0]  out_channel;
    logic [COUNT_W-1:0] out_count;
    logic [TIME_W-1:0]  out_wall_time;
    logic [TIME_W-1:0]  out_millis;
    logic [SEQ_W-1:0]   out_sequence;
    logic [LEVEL_W-1:0] queue_level;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic latch_in;
    logic commit;
    logic rd_issue;
    logic pop_commit;
    logic load_out;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_pop;
  } dp_status_t;

endpackage

### rtl/decq_in_if.sv
`timescale 1ns / 1ps
// input channel of the debounced event counter queue: valid/ready plus item fields
// depends on decq_pkg
interface decq_in_if;
  logic                          valid;
  logic                          ready;
  logic [decq_pkg::CMD_W-1:0]    cmd;
  logic [decq_pkg::CHAN_W-1:0]   channel;
  logic [decq_pkg::MASK_W-1:0]   reset_low_mask;
  logic [decq_pkg::TIME_W-1:0]   now_ms;
  logic [decq_pkg::TIME_W-1:0]   wall_time;

  modport source (output valid, cmd, channel, reset_low_mask, now_ms, wall_time,
                  input ready);
  modport sink (input valid, cmd, channel, reset_low_mask, now_ms, wall_time,
                output ready);
endinterface

### rtl/decq_out_if.sv
`timescale 1ns / 1ps
// result channel of the debounced event counter queue: valid/ready plus result fields
// depends on decq_pkg
interface decq_out_if;
  logic                          valid;
  logic                          ready;
  logic                          edge_accepted;
  logic                          event_queued;
  logic                          event_dropped;
  logic                          reset_done;
  logic                          event_valid;
  logic [decq_pkg::CHAN_W-1:0]   out_channel;
  logic [decq_pkg::COUNT_W-1:0]  out_count;
  logic [decq_pkg::TIME_W-1:0]   out_wall_time;
  logic [decq_pkg::TIME_W-1:0]   out_millis;
  logic [decq_pkg::SEQ_W-1:0]    out_sequence;
  logic [decq_pkg::LEVEL_W-1:0]  queue_level;

  modport source (output valid, edge_accepted, event_queued, event_dropped, reset_done,
                  event_valid, out_channel, out_count, out_wall_time, out_millis,
                  out_sequence, queue_level,
                  input ready);
  modport sink (input valid, edge_accepted, event_queued, event_dropped, reset_done,
                event_valid, out_channel, out_count, out_wall_time, out_millis,
                out_sequence, queue_level,
                output ready);
endinterface

### rtl/debounced_event_counter_queue_core.sv
`timescale 1ns / 1ps
// Three-channel debounced pulse counter with a 64-entry event queue. Every transaction
// carries one command (falling edge, reset sample, pop) and yields exactly one result.
// An edge, reset sample or unused command goes from the input register through the execute
// state into the result register; a pop also passes through the pop state, which covers
// the registered read of the queue memory. One transaction is in execution at a time; a
// new one is accepted while the previous result still waits in the output register, and
// execution stalls only if that register is still full. The queue memory needs no clearing
// after reset. Configuration writes (debounce time, almost-full level) are taken on any
// cycle with cfg_we high.
// depends on decq_pkg, decq_in_if, decq_out_if, decq_ctrl, decq_dp
module debounced_event_counter_queue_core (
  input  logic                              clk,
  input  logic                              rst_n,
  decq_in_if.sink                           in_if,
  decq_out_if.source                        out_if,
  input  logic                              cfg_we,
  input  logic [decq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [decq_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  decq_pkg::dp_cmd_t    dp_cmd;
  decq_pkg::dp_status_t dp_status;
  decq_pkg::in_item_t   in_item;
  decq_pkg::result_t    res;

  assign in_item.cmd            = in_if.cmd;
  assign in_item.channel        = in_if.channel;
  assign in_item.reset_low_mask = in_if.reset_low_mask;
  assign in_item.now_ms         = in_if.now_ms;
  assign in_item.wall_time      = in_if.wall_time;

  decq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .status    (dp_status),
    .cmd       (dp_cmd)
  );

  decq_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (dp_cmd),
    .status    (dp_status),
    .res_out   (res)
  );

  assign out_if.edge_accepted = res.edge_accepted;
  assign out_if.event_queued  = res.event_queued;
  assign out_if.event_dropped = res.event_dropped;
  assign out_if.reset_done    = res.reset_done;
  assign out_if.event_valid   = res.event_valid;
  assign out_if.out_channel   = res.out_channel;
  assign out_if.out_count     = res.out_count;
  assign out_if.out_wall_time = res.out_wall_time;
  assign out_if.out_millis    = res.out_millis;
  assign out_if.out_sequence  = res.out_sequence;
  assign out_if.queue_level   = res.queue_level;

endmodule

### rtl/decq_ram.sv
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read data
// no dependencies
module decq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/decq_ctrl.sv
`timescale 1ns / 1ps
// controller of the debounced event counter queue: sequences accept, execute, pop read
// and output load; depends on decq_pkg
module decq_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  decq_pkg::dp_status_t status,
  output decq_pkg::dp_cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_POP  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status.is_pop) begin
          cmd.rd_issue = 1'b1;
          state_nxt = ST_POP;
        end else if (out_free) begin
          // state only changes once the result has a place to go
          cmd.commit = 1'b1;
          cmd.load_out = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_POP: begin
        if (out_free) begin
          cmd.pop_commit = 1'b1;
          cmd.load_out = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result loaded over an untaken result");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_EXEC))
    else $error("accepted transaction not executed");

  a_pop_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POP) |-> $past(cmd.rd_issue) || $past(state_r == ST_POP))
    else $error("pop state entered without a queue read");

  a_commit_once: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit || cmd.pop_commit) |=> !(cmd.commit || cmd.pop_commit))
    else $error("one transaction committed twice");
`endif

endmodule

### rtl/decq_dp.sv
`timescale 1ns / 1ps
// datapath of the debounced event counter queue: counters, debounce timers, queue pointers,
// config registers, event memory and result register; depends on decq_pkg and decq_ram
module decq_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  decq_pkg::in_item_t                   in_item,
  input  logic                                 cfg_we,
  input  logic [decq_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [decq_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  decq_pkg::dp_cmd_t                    cmd,
  output decq_pkg::dp_status_t                 status,
  output decq_pkg::result_t                    res_out
);

  decq_pkg::in_item_t in_r;
  decq_pkg::result_t  res_r, exec_res, pop_res;

  logic [decq_pkg::TIME_W-1:0]  debounce_r;
  logic [decq_pkg::AFL_W-1:0]   afl_r;

  logic [decq_pkg::COUNT_W-1:0] count_r     [decq_pkg::NUM_CHANNELS];
  logic [decq_pkg::TIME_W-1:0]  last_edge_r [decq_pkg::NUM_CHANNELS];
  logic [decq_pkg::TIME_W-1:0]  last_rst_r  [decq_pkg::NUM_CHANNELS];
  logic [decq_pkg::PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [decq_pkg::SEQ_W-1:0]   seq_r;

  logic [decq_pkg::PTR_W-1:0]   level, wr_ptr_inc;
  logic [decq_pkg::COUNT_W-1:0] sel_count, count_inc;
  logic [decq_pkg::TIME_W-1:0]  sel_last;
  logic                         ch_ok, edge_ok, enq_ok;
  logic [decq_pkg::NUM_CHANNELS-1:0] rst_hit;
  decq_pkg::slot_t              wr_slot, rd_slot;
  logic [decq_pkg::SLOT_W-1:0]  rd_data;

  assign status.is_pop = (in_r.cmd == decq_pkg::CMD_POP);

  assign level      = wr_ptr_r - rd_ptr_r;
  assign wr_ptr_inc = wr_ptr_r + 1'b1;

  always_comb begin
    sel_count = '0;
    sel_last  = '0;
    ch_ok     = 1'b0;
    for (int i = 0; i < decq_pkg::NUM_CHANNELS; i++) begin
      if (in_r.channel == decq_pkg::CHAN_W'(i)) begin
        sel_count = count_r[i];
        sel_last  = last_edge_r[i];
        ch_ok     = 1'b1;
      end
    end
  end

  assign count_inc = (sel_count == decq_pkg::COUNT_MAX) ? sel_count : sel_count + 1'b1;
  assign edge_ok = (in_r.cmd == decq_pkg::CMD_EDGE) && ch_ok &&
                   ((in_r.now_ms - sel_last) > debounce_r);
  assign enq_ok = (decq_pkg::CMP_W'(level) < decq_pkg::CMP_W'(afl_r)) &&
                  (wr_ptr_inc != rd_ptr_r);

  // lockout check per channel for a reset sample
  always_comb begin
    rst_hit = '0;
    for (int i = 0; i < decq_pkg::NUM_RST; i++) begin
      rst_hit[i] = (in_r.cmd == decq_pkg::CMD_RESET) && in_r.reset_low_mask[i] &&
                   ((in_r.now_ms - last_rst_r[i]) > debounce_r);
    end
  end

  always_comb begin
    exec_res = '0;
    exec_res.queue_level = decq_pkg::LEVEL_W'(level);
    if (edge_ok) begin
      exec_res.edge_accepted = 1'b1;
      exec_res.out_channel   = in_r.channel + 1'b1;
      exec_res.out_count     = count_inc;
      if (enq_ok) begin
        exec_res.event_queued = 1'b1;
        exec_res.out_sequence = seq_r;
        exec_res.queue_level  = decq_pkg::LEVEL_W'(wr_ptr_inc - rd_ptr_r);
      end else begin
        exec_res.event_dropped = 1'b1;
      end
    end
    // ascending scan so the highest channel wins
    for (int i = 0; i < decq_pkg::NUM_RST; i++) begin
      if (rst_hit[i] && (count_r[i] != '0)) begin
        exec_res.reset_done  = 1'b1;
        exec_res.out_channel = decq_pkg::CHAN_W'(i + 1);
        exec_res.out_count   = count_r[i];
      end
    end
  end

  assign rd_slot = decq_pkg::slot_t'(rd_data);

  always_comb begin
    pop_res = '0;
    pop_res.queue_level = decq_pkg::LEVEL_W'(level);
    if (level != '0) begin
      pop_res.event_valid   = 1'b1;
      pop_res.out_channel   = rd_slot.chan;
      pop_res.out_count     = rd_slot.count;
      pop_res.out_wall_time = rd_slot.wall;
      pop_res.out_millis    = rd_slot.millis;
      pop_res.out_sequence  = rd_slot.seq;
      pop_res.queue_level   = decq_pkg::LEVEL_W'(level - 1'b1);
    end
  end

  always_comb begin
    wr_slot.chan   = in_r.channel + 1'b1;
    wr_slot.wall   = in_r.wall_time;
    wr_slot.millis = in_r.now_ms;
    wr_slot.count  = count_inc;
    wr_slot.seq    = seq_r;
  end

  decq_ram #(
    .WIDTH (decq_pkg::SLOT_W),
    .DEPTH (decq_pkg::QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.commit && edge_ok && enq_ok),
    .waddr (wr_ptr_r),
    .wdata (wr_slot),
    .re    (cmd.rd_issue),
    .raddr (rd_ptr_r),
    .rdata (rd_data)
  );

  // input item and result registers
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      in_r <= in_item;
    end
    if (cmd.load_out) begin
      res_r <= cmd.pop_commit ? pop_res : exec_res;
    end
  end

  assign res_out = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= decq_pkg::DEBOUNCE_RESET;
      afl_r      <= decq_pkg::AFL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        decq_pkg::REG_DEBOUNCE_MS: debounce_r <= cfg_wdata;
        decq_pkg::REG_ALMOST_FULL: afl_r <= cfg_wdata[decq_pkg::AFL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < decq_pkg::NUM_CHANNELS; i++) begin
        count_r[i]     <= '0;
        last_edge_r[i] <= '0;
        last_rst_r[i]  <= '0;
      end
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      seq_r    <= '0;
    end else begin
      if (cmd.commit) begin
        for (int i = 0; i < decq_pkg::NUM_CHANNELS; i++) begin
          if (edge_ok && (in_r.channel == decq_pkg::CHAN_W'(i))) begin
            count_r[i]     <= count_inc;
            last_edge_r[i] <= in_r.now_ms;
          end
        end
        for (int i = 0; i < decq_pkg::NUM_RST; i++) begin
          if (rst_hit[i]) begin
            count_r[i]    <= '0;
            last_rst_r[i] <= in_r.now_ms;
          end
        end
        if (edge_ok && enq_ok) begin
          wr_ptr_r <= wr_ptr_inc;
          seq_r    <= seq_r + 1'b1;
        end
      end
      if (cmd.pop_commit && (level != '0)) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_wr_ptr_only_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.commit |=> $stable(wr_ptr_r))
    else $error("write pointer moved without a committed transaction");

  a_queue_never_full: assert property (@(posedge clk) disable iff (!rst_n)
    wr_ptr_inc == rd_ptr_r |=> !$changed(wr_ptr_r))
    else $error("write pointer advanced into a full queue");
`endif

endmodule

### dv/debounced_event_counter_queue_core_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the debounced event counter queue core: a directed table,
// then random phases under changing debounce and almost-full settings and idle patterns
// depends on decq_pkg, decq_in_if, decq_out_if and debounced_event_counter_queue_core
module debounced_event_counter_queue_core_tb;

  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 11;
  localparam int SETTLE_CYCLES   = 8;
  localparam int CYCLE_LIMIT     = 300000;
  localparam int NUM_PHASES      = 9;
  localparam int ITEMS_PER_PHASE = 190;
  localparam int HOLD_AFTER      = 300;
  localparam int HOLD_CYCLES     = 400;
  localparam int MAX_REPORTS     = 100;
  localparam logic [decq_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_LITERAL, ROW_CONFIG} row_kind_t;

  typedef struct {
    row_kind_t                   kind;
    decq_pkg::in_item_t          item;
    decq_pkg::result_t           lit;
    logic [decq_pkg::TIME_W-1:0] deb;
    logic [decq_pkg::AFL_W-1:0]  afl;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                            cfg_we;
  logic [decq_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [decq_pkg::CFG_DATA_W-1:0] cfg_wdata;

  decq_in_if  in_bus ();
  decq_out_if out_bus ();

  debounced_event_counter_queue_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_bus),
    .out_if    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // predictor state
  logic [decq_pkg::TIME_W-1:0]  debounce_cfg;
  logic [decq_pkg::AFL_W-1:0]   afl_cfg;
  logic [decq_pkg::COUNT_W-1:0] ch_count      [decq_pkg::NUM_CHANNELS];
  logic [decq_pkg::TIME_W-1:0]  ch_last_edge  [decq_pkg::NUM_CHANNELS];
  logic [decq_pkg::TIME_W-1:0]  ch_last_reset [decq_pkg::NUM_CHANNELS];
  decq_pkg::slot_t              event_slots   [decq_pkg::QUEUE_DEPTH];
  logic [decq_pkg::PTR_W-1:0]   rd_ptr;
  logic [decq_pkg::PTR_W-1:0]   wr_ptr;
  logic [decq_pkg::SEQ_W-1:0]   seq_next;

  decq_pkg::result_t expected_results [$];
  dir_row_t          dir_rows [$];
  decq_pkg::result_t got_result;
  decq_pkg::result_t want_result;

  int mismatch_cnt  = 0;
  int results_seen  = 0;
  int cycle_cnt     = 0;
  int snd_idle      = 35;
  int rcv_idle      = 54;
  bit long_hold_done = 1'b0;

  function automatic decq_pkg::result_t predict_result(input decq_pkg::in_item_t it);
    decq_pkg::result_t            r;
    int                           ch;
    int                           i;
    logic [decq_pkg::PTR_W-1:0]   nxt;
    logic [decq_pkg::LEVEL_W-1:0] lvl;
    r   = '0;
    ch  = int'(it.channel);
    lvl = wr_ptr - rd_ptr;
    case (it.cmd)
      decq_pkg::CMD_EDGE: begin
        if (ch < decq_pkg::NUM_CHANNELS) begin
          if (decq_pkg::TIME_W'(it.now_ms - ch_last_edge[ch]) > debounce_cfg) begin
            ch_last_edge[ch] = it.now_ms;
            if (ch_count[ch] != decq_pkg::COUNT_MAX) ch_count[ch] = ch_count[ch] + 1'b1;
            r.edge_accepted = 1'b1;
            r.out_channel   = decq_pkg::CHAN_W'(ch + 1);
            r.out_count     = ch_count[ch];
            nxt = wr_ptr + 1'b1;
            if ({1'b0, lvl} < afl_cfg && nxt != rd_ptr) begin
              event_slots[wr_ptr].chan   = decq_pkg::CHAN_W'(ch + 1);
              event_slots[wr_ptr].wall   = it.wall_time;
              event_slots[wr_ptr].millis = it.now_ms;
              event_slots[wr_ptr].count  = ch_count[ch];
              event_slots[wr_ptr].seq    = seq_next;
              r.event_queued = 1'b1;
              r.out_sequence = seq_next;
              seq_next = seq_next + 1'b1;
              wr_ptr   = nxt;
            end else begin
              r.event_dropped = 1'b1;
            end
          end
        end
      end
      decq_pkg::CMD_RESET: begin
        // highest channel wins the report since the loop runs upward
        for (i = 0; i < decq_pkg::NUM_RST; i++) begin
          if (it.reset_low_mask[i] &&
              decq_pkg::TIME_W'(it.now_ms - ch_last_reset[i]) > debounce_cfg) begin
            if (ch_count[i] != '0) begin
              r.reset_done  = 1'b1;
              r.out_channel = decq_pkg::CHAN_W'(i + 1);
              r.out_count   = ch_count[i];
              ch_count[i]   = '0;
            end
            ch_last_reset[i] = it.now_ms;
          end
        end
      end
      decq_pkg::CMD_POP: begin
        if (lvl != '0) begin
          r.event_valid   = 1'b1;
          r.out_channel   = event_slots[rd_ptr].chan;
          r.out_count     = event_slots[rd_ptr].count;
          r.out_wall_time = event_slots[rd_ptr].wall;
          r.out_millis    = event_slots[rd_ptr].millis;
          r.out_sequence  = event_slots[rd_ptr].seq;
          rd_ptr = rd_ptr + 1'b1;
        end
      end
      default: ;
    endcase
    r.queue_level = wr_ptr - rd_ptr;
    return r;
  endfunction

  function automatic dir_row_t item_row(input logic [decq_pkg::CMD_W-1:0] cmd,
                                        input logic [decq_pkg::CHAN_W-1:0] ch,
                                        input logic [decq_pkg::MASK_W-1:0] mask,
                                        input logic [decq_pkg::TIME_W-1:0] now, wall);
    dir_row_t r;
    r.kind = ROW_PREDICT;
    r.item = '{cmd, ch, mask, now, wall};
    r.lit  = '0;
    r.deb  = '0;
    r.afl  = '0;
    return r;
  endfunction

  function automatic dir_row_t literal_row(input dir_row_t base,
                                           input decq_pkg::result_t lit);
    base.kind = ROW_LITERAL;
    base.lit  = lit;
    return base;
  endfunction

  function automatic dir_row_t config_row(input logic [decq_pkg::TIME_W-1:0] deb,
                                          input logic [decq_pkg::AFL_W-1:0] afl);
    dir_row_t r;
    r = item_row(CMD_UNUSED, '0, '0, '0, '0);
    r.kind = ROW_CONFIG;
    r.deb  = deb;
    r.afl  = afl;
    return r;
  endfunction

  function automatic decq_pkg::result_t idle_result(
      input logic [decq_pkg::LEVEL_W-1:0] lvl);
    decq_pkg::result_t r;
    r = '0;
    r.queue_level = lvl;
    return r;
  endfunction

  function automatic decq_pkg::result_t queued_result(
      input logic [decq_pkg::CHAN_W-1:0] ch,
      input logic [decq_pkg::COUNT_W-1:0] cnt,
      input logic [decq_pkg::SEQ_W-1:0] seq,
      input logic [decq_pkg::LEVEL_W-1:0] lvl);
    decq_pkg::result_t r;
    r = '0;
    r.edge_accepted = 1'b1;
    r.event_queued  = 1'b1;
    r.out_channel   = ch;
    r.out_count     = cnt;
    r.out_sequence  = seq;
    r.queue_level   = lvl;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS)
      $display("[%0t] mismatch at result %0d: %s", $time, results_seen, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got, want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  // called at a falling edge; returns at a falling edge
  task automatic send_item(input decq_pkg::in_item_t it, input bit use_lit,
                           input decq_pkg::result_t lit);
    decq_pkg::result_t want;
    while ($urandom_range(0, 99) < snd_idle) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid          <= 1'b1;
    in_bus.cmd            <= it.cmd;
    in_bus.channel        <= it.channel;
    in_bus.reset_low_mask <= it.reset_low_mask;
    in_bus.now_ms         <= it.now_ms;
    in_bus.wall_time      <= it.wall_time;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    want = predict_result(it);
    expected_results.push_back(use_lit ? lit : want);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_bus.valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_regs(input logic [decq_pkg::TIME_W-1:0] deb,
                            input logic [decq_pkg::AFL_W-1:0] afl);
    cfg_we    <= 1'b1;
    cfg_index <= decq_pkg::REG_DEBOUNCE_MS;
    cfg_wdata <= decq_pkg::CFG_DATA_W'(deb);
    @(negedge clk);
    cfg_index <= decq_pkg::REG_ALMOST_FULL;
    cfg_wdata <= decq_pkg::CFG_DATA_W'(afl);
    @(negedge clk);
    cfg_we <= 1'b0;
    debounce_cfg = deb;
    afl_cfg      = afl;
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got_result.edge_accepted = out_bus.edge_accepted;
      got_result.event_queued  = out_bus.event_queued;
      got_result.event_dropped = out_bus.event_dropped;
      got_result.reset_done    = out_bus.reset_done;
      got_result.event_valid   = out_bus.event_valid;
      got_result.out_channel   = out_bus.out_channel;
      got_result.out_count     = out_bus.out_count;
      got_result.out_wall_time = out_bus.out_wall_time;
      got_result.out_millis    = out_bus.out_millis;
      got_result.out_sequence  = out_bus.out_sequence;
      got_result.queue_level   = out_bus.queue_level;
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("result with no transaction pending");
      end else begin
        want_result = expected_results.pop_front();
        check_field("edge_accepted", got_result.edge_accepted, want_result.edge_accepted);
        check_field("event_queued", got_result.event_queued, want_result.event_queued);
        check_field("event_dropped", got_result.event_dropped, want_result.event_dropped);
        check_field("reset_done", got_result.reset_done, want_result.reset_done);
        check_field("event_valid", got_result.event_valid, want_result.event_valid);
        check_field("out_channel", got_result.out_channel, want_result.out_channel);
        check_field("out_count", got_result.out_count, want_result.out_count);
        check_field("out_wall_time", got_result.out_wall_time, want_result.out_wall_time);
        check_field("out_millis", got_result.out_millis, want_result.out_millis);
        check_field("out_sequence", got_result.out_sequence, want_result.out_sequence);
        check_field("queue_level", got_result.queue_level, want_result.queue_level);
      end
    end
  end

  // receiver: random back-pressure plus one long hold-off to fill the block
  initial begin
    int hold_cnt;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!long_hold_done && results_seen >= HOLD_AFTER) begin
        out_bus.ready <= 1'b0;
        for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(negedge clk);
        long_hold_done = 1'b1;
      end
      out_bus.ready <= ($urandom_range(0, 99) >= rcv_idle);
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    decq_pkg::in_item_t          it;
    int                          ph;
    int                          n;
    int                          pick;
    int                          pop_pct;
    logic [decq_pkg::TIME_W-1:0] deb;
    logic [decq_pkg::AFL_W-1:0]  afl;
    logic [decq_pkg::TIME_W-1:0] base_ms;

    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_index             = decq_pkg::REG_DEBOUNCE_MS;
    cfg_wdata             = '0;
    in_bus.valid          = 1'b0;
    in_bus.cmd            = decq_pkg::CMD_EDGE;
    in_bus.channel        = '0;
    in_bus.reset_low_mask = '0;
    in_bus.now_ms         = '0;
    in_bus.wall_time      = '0;

    debounce_cfg = decq_pkg::DEBOUNCE_RESET;
    afl_cfg      = decq_pkg::AFL_RESET;
    for (n = 0; n < decq_pkg::NUM_CHANNELS; n++) begin
      ch_count[n]      = '0;
      ch_last_edge[n]  = '0;
      ch_last_reset[n] = '0;
    end
    rd_ptr   = '0;
    wr_ptr   = '0;
    seq_next = '0;
    base_ms  = 32'h0000_1000;

    // reset-time settings: debounce 500, almost full 58
    dir_rows.push_back(literal_row(item_row(decq_pkg::CMD_POP, 2'd0, 3'd0, 32'd0, 32'd0),
                                   idle_result(6'd0)));
    dir_rows.push_back(literal_row(item_row(CMD_UNUSED, 2'd3, 3'd7, '1, '1),
                                   idle_result(6'd0)));
    // exactly the lockout time is still rejected
    dir_rows.push_back(literal_row(item_row(decq_pkg::CMD_EDGE, 2'd0, 3'd0, 32'd500, 32'd1),
                                   idle_result(6'd0)));
    dir_rows.push_back(literal_row(item_row(decq_pkg::CMD_EDGE, 2'd0, 3'd0, 32'd501, '1),
                                   queued_result(2'd1, 31'd1, 31'd0, 6'd1)));
    dir_rows.push_back(literal_row(item_row(decq_pkg::CMD_EDGE, 2'd3, 3'd7, '1, '1),
                                   idle_result(6'd1)));
    dir_rows.push_back(literal_row(item_row(decq_pkg::CMD_EDGE, 2'd2, 3'd0, '1, 32'd0),
                                   queued_result(2'd3, 31'd1, 31'd1, 6'd2)));
    // time wraps past 2^32
    dir_rows.push_back(item_row(decq_pkg::CMD_EDGE, 2'd2, 3'd0, 32'd0, 32'h5555_5555));
    dir_rows.push_back(item_row(decq_pkg::CMD_EDGE, 2'd2, 3'd0, 32'd500, 32'hAAAA_AAAA));
    dir_rows.push_back(item_row(decq_pkg::CMD_EDGE, 2'd1, 3'd0, 32'h8000_0000,
                                32'h1234_5678));
    dir_rows.push_back(item_row(decq_pkg::CMD_RESET, 2'd0, 3'd0, 32'd1000, 32'd0));
    dir_rows.push_back(item_row(decq_pkg::CMD_RESET, 2'd0, 3'd7, 32'd501, 32'd0));
    dir_rows.push_back(item_row(decq_pkg::CMD_RESET, 2'd0, 3'd7, 32'd600, 32'd0));
    dir_rows.push_back(item_row(decq_pkg::CMD_RESET, 2'd3, 3'd7, '1, 32'd0));
    for (n = 0; n < 5; n++)
      dir_rows.push_back(item_row(decq_pkg::CMD_POP, 2'd0, 3'd0, 32'd0, 32'd0));
    dir_rows.push_back(config_row(32'd0, 7'd1));
    dir_rows.push_back(item_row(decq_pkg::CMD_EDGE, 2'd0, 3'd0, 32'd5, 32'hDEAD_BEEF));
    dir_rows.push_back(item_row(decq_pkg::CMD_EDGE, 2'd0, 3'd0, 32'd6, 32'hCAFE_F00D));
    dir_rows.push_back(item_row(decq_pkg::CMD_EDGE, 2'd0, 3'd0, 32'd6, 32'd7));
    // every accepted edge dropped
    dir_rows.push_back(config_row(32'd0, 7'd0));
    dir_rows.push_back(item_row(decq_pkg::CMD_EDGE, 2'd1, 3'd0, 32'd7, 32'd8));
    // lockout can never be exceeded
    dir_rows.push_back(config_row('1, decq_pkg::AFL_RESET));
    dir_rows.push_back(item_row(decq_pkg::CMD_EDGE, 2'd2, 3'd0, 32'h1234_5678, 32'd9));
    dir_rows.push_back(item_row(decq_pkg::CMD_RESET, 2'd0, 3'd7, 32'd0, 32'd0));
    dir_rows.push_back(item_row(decq_pkg::CMD_POP, 2'd0, 3'd0, 32'd0, 32'd0));
    dir_rows.push_back(item_row(decq_pkg::CMD_POP, 2'd0, 3'd0, 32'd0, 32'd0));

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_CONFIG: begin
          drain_results();
          write_regs(dir_rows[i].deb, dir_rows[i].afl);
        end
        ROW_LITERAL: send_item(dir_rows[i].item, 1'b1, dir_rows[i].lit);
        default:     send_item(dir_rows[i].item, 1'b0, '0);
      endcase
    end

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      drain_results();
      case (ph)
        0: begin deb = 32'd500; afl = 7'd58; pop_pct = 30; end
        1: begin deb = 32'd0; afl = 7'd64; pop_pct = 8; end
        2: begin
          deb = $urandom_range(0, 40);
          afl = decq_pkg::AFL_W'($urandom_range(1, 64));
          pop_pct = 30;
        end
        3: begin deb = $urandom; afl = 7'd58; pop_pct = 25; end
        4: begin deb = 32'd1; afl = 7'd1; pop_pct = 30; end
        5: begin deb = 32'd200; afl = 7'd64; pop_pct = 8; end
        6: begin deb = 32'd500; afl = 7'd58; pop_pct = 45; end
        7: begin
          deb = $urandom_range(0, 300);
          afl = decq_pkg::AFL_W'($urandom_range(0, 64));
          pop_pct = 20;
        end
        default: begin deb = 32'd20; afl = 7'd32; pop_pct = 15; end
      endcase
      write_regs(deb, afl);
      case (ph / 3)
        0:       begin snd_idle = 35; rcv_idle = 54; end
        1:       begin snd_idle = 54; rcv_idle = 35; end
        default: begin snd_idle = 0;  rcv_idle = 0;  end
      endcase

      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < pop_pct)           it.cmd = decq_pkg::CMD_POP;
        else if (pick < pop_pct + 10) it.cmd = decq_pkg::CMD_RESET;
        else if (pick < pop_pct + 13) it.cmd = CMD_UNUSED;
        else                          it.cmd = decq_pkg::CMD_EDGE;
        it.channel        = ($urandom_range(0, 19) == 0) ? 2'd3
                            : decq_pkg::CHAN_W'($urandom_range(0, 2));
        it.reset_low_mask = decq_pkg::MASK_W'($urandom_range(0, 7));
        it.wall_time      = $urandom;
        // mostly a clock that moves on around the lockout time, sometimes a wild jump
        if ($urandom_range(0, 9) == 0) begin
          it.now_ms = $urandom;
        end else begin
          if (debounce_cfg <= 32'd2000)
            base_ms = base_ms + $urandom_range(0, 2 * debounce_cfg + 4);
          else
            base_ms = base_ms + $urandom;
          it.now_ms = base_ms;
        end
        send_item(it, 1'b0, '0);
      end
    end

    drain_results();
    if (mismatch_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
